// ----- rtl/bpsktx_pkg.sv -----
// bpsktx_pkg: shared codes, constants and the fixed-point sine for the bpsk frame transmitter
// no dependencies; imported by bpsk_frame_transmitter_top and tb_top
`timescale 1ns / 1ps

package bpsktx_pkg;

  // input item kinds carried on s_axis_tuser
  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_START = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SAMPLES_PER_BIT = 2'd0,
    CFG_PHASE_STEP      = 2'd1,
    CFG_ZERO_PAD_LEN    = 2'd2,
    CFG_WARMUP_LEN      = 2'd3
  } cfg_reg_e;

  // what the sample stage has to produce for one item
  typedef enum logic [1:0] {
    SK_ZERO    = 2'd0,
    SK_CARRIER = 2'd1,
    SK_DATA    = 2'd2,
    SK_HEADER  = 2'd3
  } sample_kind_e;

  // chirp sweep and sample rate
  localparam int unsigned START_HZ  = 2000;
  localparam int unsigned END_HZ    = 10000;
  localparam int unsigned RATE_HZ   = 48000;
  localparam int unsigned CHIRP_DIV = 2 * RATE_HZ;

  // quarter-wave polynomial coefficients, Q15
  localparam logic [31:0] QA = 32'd51472;
  localparam logic [31:0] QB = 32'd21024;
  localparam logic [31:0] QC = 32'd2320;

  // register reset values
  localparam logic [6:0]  SPB_RESET   = 7'd8;
  localparam logic [15:0] STEP_RESET  = 16'd6827;
  localparam logic [7:0]  PAD_RESET   = 8'd20;
  localparam logic [9:0]  WARM_RESET  = 10'd480;
  localparam logic [6:0]  SPB_MAX     = 7'd64;

  // x*(A - x2*(B - C*x2)) with each product truncated by 15 bits
  function automatic logic [15:0] quarter_poly(logic [31:0] x);
    logic [31:0] x2;
    logic [31:0] t;
    x2 = (x * x) >> 15;
    t  = QB - ((QC * x2) >> 15);
    t  = QA - ((t * x2) >> 15);
    t  = (t * x) >> 15;
    return (t > 32'd32767) ? 16'd32767 : t[15:0];
  endfunction

  // sine of a 16-bit phase, 65536 per full turn, Q1.15
  function automatic logic signed [15:0] sin_q15(logic [15:0] p);
    logic [1:0]  q;
    logic [31:0] x;
    logic [15:0] v;
    q = p[15:14];
    x = {17'd0, p[13:0], 1'b0};
    v = q[0] ? quarter_poly(32'd32768 - x) : quarter_poly(x);
    return q[1] ? -$signed(v) : $signed(v);
  endfunction

endpackage

// ----- rtl/bpsktx_ram.sv -----
// bpsktx_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module bpsktx_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- rtl/bpsk_frame_transmitter_top.sv -----
// bpsk_frame_transmitter_top: frame bit store, transmit sequencer and sample output stage
// depends on bpsktx_pkg and bpsktx_ram
`timescale 1ns / 1ps

// BPSK frame transmitter. Load transfers (tuser 0) write frame bits into an on-chip bit
// store, tlast on a load closes the frame. A start transfer (tuser 2) arms a carrier
// warm-up. Each tick transfer (tuser 1) returns one Q1.15 sample: warm-up carrier, then
// for a ready frame the chirp preamble, the data bits as +/- carrier, and zero padding.
// Every input transfer returns exactly one result transfer. The block takes one item per
// clock cycle unless the result stream holds it off; a result passes the stage 1 registers
// and then the output register. The sequencer updates all counters in the cycle of the
// transfer and issues the bit store read, whose registered data and the cosine and preamble
// tables feed the output stage. The bit store needs no clearing after reset.
module bpsk_frame_transmitter_top
  import bpsktx_pkg::*;
#(
  parameter int MAX_FRAME_BITS  = 1024,
  parameter int PREAMBLE_LEN    = 120,
  parameter int COS_TABLE_DEPTH = 256,
  parameter int SAMPLE_WIDTH    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input item stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] data_bit, [7:1] zero
  input  logic        s_axis_tlast,   // end_of_frame
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] sample
  output logic [2:0]  m_axis_tuser,   // [0] sample_valid, [1] playing, [2] load_refused
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int LEN_W      = $clog2(MAX_FRAME_BITS + 1);
  localparam int ADDR_W     = $clog2(MAX_FRAME_BITS);
  localparam int HDR_AW     = $clog2(PREAMBLE_LEN);
  localparam int COS_AW     = $clog2(COS_TABLE_DEPTH);
  localparam int HALF_LEN   = PREAMBLE_LEN / 2;
  localparam int CHIRP_STEP = (END_HZ - START_HZ) / HALF_LEN;
  localparam int QUANT_BITS = (SAMPLE_WIDTH < 16) ? 16 - SAMPLE_WIDTH : 0;
  localparam logic [15:0] SAMPLE_MASK = 16'(~((32'd1 << QUANT_BITS) - 32'd1));

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_WARMUP = 3'd1,
    PH_HEADER = 3'd2,
    PH_DATA   = 3'd3,
    PH_PAD    = 3'd4
  } tx_phase_e;

  // chirp frequency at preamble sample i
  function automatic int unsigned chirp_freq(int unsigned i);
    if (i < HALF_LEN) return START_HZ + CHIRP_STEP * i;
    if (i == HALF_LEN) return END_HZ;
    return END_HZ - CHIRP_STEP * (i - HALF_LEN);
  endfunction

  // preamble sample i from the integrated chirp phase
  function automatic logic signed [15:0] chirp_sample(int unsigned i);
    logic [63:0] acc;
    logic [63:0] p;
    acc = 64'd0;
    for (int unsigned j = 1; j <= i; j++) begin
      acc = acc + 64'(chirp_freq(j)) + 64'(chirp_freq(j - 1));
    end
    p = (acc * 64'd65536 + 64'(RATE_HZ)) / CHIRP_DIV;
    return (i == 0) ? 16'sd0 : sin_q15(p[15:0]);
  endfunction

  // quantized carrier value for table entry k
  function automatic logic signed [15:0] cos_entry(int unsigned k);
    logic [31:0] p;
    p = (32'(k) << 16) / COS_TABLE_DEPTH;
    return sin_q15(16'(p + 32'd16384));
  endfunction

  // constant tables
  logic signed [15:0] hdr_rom [PREAMBLE_LEN];
  logic signed [15:0] cos_rom [COS_TABLE_DEPTH];

  for (genvar g = 0; g < PREAMBLE_LEN; g++) begin : g_hdr
    assign hdr_rom[g] = chirp_sample(g);
  end

  for (genvar g = 0; g < COS_TABLE_DEPTH; g++) begin : g_cos
    assign cos_rom[g] = cos_entry(g);
  end

  // configuration registers
  logic [6:0]  spb_q;
  logic [15:0] step_q;
  logic [7:0]  pad_q;
  logic [9:0]  warm_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spb_q  <= SPB_RESET;
      step_q <= STEP_RESET;
      pad_q  <= PAD_RESET;
      warm_q <= WARM_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_SAMPLES_PER_BIT: spb_q  <= cfg_data_i[6:0];
        CFG_PHASE_STEP:      step_q <= cfg_data_i;
        CFG_ZERO_PAD_LEN:    pad_q  <= cfg_data_i[7:0];
        CFG_WARMUP_LEN:      warm_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake: stage 1 then output register
  logic s1_valid_q;
  logic out_valid_q;
  logic adv;
  logic in_xfer;

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || adv;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // sequencer state
  tx_phase_e        phase_q, phase_d;
  logic             ready_q, ready_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [9:0]       pc_q, pc_d;
  logic [LEN_W-1:0] bidx_q, bidx_d;
  logic [5:0]       sib_q, sib_d;
  logic [15:0]      acc_q, acc_d;

  // per-item results of the sequencer
  sample_kind_e      kind;
  logic              valid_flag;
  logic              refused;
  logic              mem_we;
  logic [HDR_AW-1:0] hdr_idx;
  logic [COS_AW-1:0] cos_idx;

  // helpers
  action_e     action;
  tx_phase_e   ph_cur;
  logic [9:0]  pc_cur;
  logic [6:0]  spb_eff;
  logic [6:0]  sib_inc;
  logic [10:0] pc_inc;
  logic [LEN_W-1:0] bidx_inc;
  logic        bit_wrap;
  logic [31:0] cos_prod;

  assign action   = action_e'(s_axis_tuser);
  assign spb_eff  = (spb_q == 7'd0) ? 7'd1 : ((spb_q > SPB_MAX) ? SPB_MAX : spb_q);
  assign sib_inc  = {1'b0, sib_q} + 7'd1;
  assign bit_wrap = sib_inc >= spb_eff;
  assign bidx_inc = bidx_q + LEN_W'(1);
  assign cos_prod = 32'(acc_q) * 32'(COS_TABLE_DEPTH);
  assign cos_idx  = cos_prod[16 +: COS_AW];

  // a ready frame starts its preamble on a tick while idle
  always_comb begin
    if (phase_q == PH_IDLE && ready_q) begin
      ph_cur = PH_HEADER;
      pc_cur = 10'd0;
    end else begin
      ph_cur = phase_q;
      pc_cur = pc_q;
    end
  end

  assign pc_inc  = {1'b0, pc_cur} + 11'd1;
  assign hdr_idx = pc_cur[HDR_AW-1:0];

  // next-state logic of the sequencer
  always_comb begin
    phase_d    = phase_q;
    ready_d    = ready_q;
    len_d      = len_q;
    pc_d       = pc_q;
    bidx_d     = bidx_q;
    sib_d      = sib_q;
    acc_d      = acc_q;
    kind       = SK_ZERO;
    valid_flag = 1'b0;
    refused    = 1'b0;
    mem_we     = 1'b0;
    case (action)
      ACT_LOAD: begin
        if (ready_q || len_q >= LEN_W'(MAX_FRAME_BITS)) begin
          refused = 1'b1;
        end else begin
          mem_we = 1'b1;
          len_d  = len_q + LEN_W'(1);
          if (s_axis_tlast) ready_d = 1'b1;
        end
      end
      ACT_START: begin
        if (phase_q == PH_IDLE && warm_q != 10'd0) begin
          phase_d = PH_WARMUP;
          pc_d    = 10'd0;
          sib_d   = 6'd0;
          acc_d   = 16'd0;
        end
      end
      ACT_TICK: begin
        valid_flag = 1'b1;
        phase_d    = ph_cur;
        pc_d       = pc_cur;
        case (ph_cur)
          PH_WARMUP: begin
            kind  = SK_CARRIER;
            sib_d = bit_wrap ? 6'd0 : sib_inc[5:0];
            acc_d = bit_wrap ? 16'd0 : acc_q + step_q;
            pc_d  = pc_inc[9:0];
            if (pc_inc >= {1'b0, warm_q}) begin
              phase_d = PH_IDLE;
              pc_d    = 10'd0;
            end
          end
          PH_HEADER: begin
            kind = ({1'b0, pc_cur} < 11'(PREAMBLE_LEN)) ? SK_HEADER : SK_ZERO;
            pc_d = pc_inc[9:0];
            if (pc_inc >= 11'(PREAMBLE_LEN)) begin
              phase_d = PH_DATA;
              pc_d    = 10'd0;
              bidx_d  = '0;
              sib_d   = 6'd0;
              acc_d   = 16'd0;
            end
          end
          PH_DATA: begin
            kind  = SK_DATA;
            sib_d = sib_inc[5:0];
            acc_d = acc_q + step_q;
            if (bit_wrap) begin
              sib_d  = 6'd0;
              acc_d  = 16'd0;
              bidx_d = bidx_inc;
              if (bidx_inc >= len_q) begin
                phase_d = PH_PAD;
                pc_d    = 10'd0;
                if (pad_q == 8'd0) begin
                  ready_d = 1'b0;
                  len_d   = '0;
                  phase_d = PH_IDLE;
                end
              end
            end
          end
          PH_PAD: begin
            pc_d = pc_inc[9:0];
            if (pc_inc >= {3'd0, pad_q}) begin
              ready_d = 1'b0;
              len_d   = '0;
              phase_d = PH_IDLE;
              pc_d    = 10'd0;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // sequencer registers, advanced on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      ready_q <= 1'b0;
      len_q   <= '0;
      pc_q    <= 10'd0;
      bidx_q  <= '0;
      sib_q   <= 6'd0;
      acc_q   <= 16'd0;
    end else if (in_xfer) begin
      phase_q <= phase_d;
      ready_q <= ready_d;
      len_q   <= len_d;
      pc_q    <= pc_d;
      bidx_q  <= bidx_d;
      sib_q   <= sib_d;
      acc_q   <= acc_d;
    end
  end

  // frame bit store
  logic rd_bit;

  bpsktx_ram #(
    .WIDTH (1),
    .DEPTH (MAX_FRAME_BITS)
  ) u_bit_store (
    .clk_i   (clk_i),
    .we_i    (in_xfer && mem_we),
    .waddr_i (len_q[ADDR_W-1:0]),
    .wdata_i (s_axis_tdata[0]),
    .re_i    (in_xfer),
    .raddr_i (bidx_q[ADDR_W-1:0]),
    .rdata_o (rd_bit)
  );

  // stage 1 registers
  sample_kind_e      s1_kind_q;
  logic [HDR_AW-1:0] s1_hdr_q;
  logic [COS_AW-1:0] s1_cos_q;
  logic [2:0]        s1_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= in_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_kind_q <= kind;
      s1_hdr_q  <= hdr_idx;
      s1_cos_q  <= cos_idx;
      s1_user_q <= {refused, (phase_d != PH_IDLE) || ready_d, valid_flag};
    end
  end

  // sample selection from the tables and the stored bit
  logic signed [15:0] cos_val;
  logic signed [15:0] sample_raw;

  assign cos_val = cos_rom[s1_cos_q];

  always_comb begin
    case (s1_kind_q)
      SK_CARRIER: sample_raw = cos_val;
      SK_DATA:    sample_raw = rd_bit ? cos_val : -cos_val;
      SK_HEADER:  sample_raw = hdr_rom[s1_hdr_q];
      default:    sample_raw = 16'sd0;
    endcase
  end

  // output register
  logic [15:0] out_sample_q;
  logic [2:0]  out_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      out_sample_q <= sample_raw & SAMPLE_MASK;
      out_user_q   <= s1_user_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_sample_q;
  assign m_axis_tuser  = out_user_q;

endmodule

// ----- sim/tb_top.sv -----
// tb_top: self-checking bench for bpsk_frame_transmitter_top, with its own sample predictor
// depends on bpsktx_pkg and the transmitter rtl; stimulus queue, stream driver, result monitor
`timescale 1ns / 1ps

module tb_top;
  import bpsktx_pkg::*;

  localparam int MAX_BITS  = 1024;
  localparam int HDR_LEN   = 120;
  localparam int COS_DEPTH = 256;
  localparam int LIMIT     = 2000000;
  localparam int HOLD_LEN  = 300;

  // transmitter phases as the predictor tracks them
  typedef enum logic [2:0] {
    TX_IDLE,
    TX_WARM,
    TX_PRE,
    TX_BITS,
    TX_TAIL
  } tx_state_e;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               sample_valid;
    logic               playing;
    logic               load_refused;
  } tx_result_t;

  typedef struct {
    action_e act;
    bit      dbit;
    bit      eof;
  } tx_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  // stimulus and expected samples
  tx_item_t   stim_q[$];
  tx_result_t due_results[$];
  int         queued_items = 0;

  // predictor state and its copy of the registers
  bit          bit_mem[MAX_BITS];
  int          frm_len = 0;
  bit          frm_rdy = 1'b0;
  tx_state_e   tx_st = TX_IDLE;
  int          ph_cnt = 0;
  int          bit_idx = 0;
  int          sib = 0;
  logic [15:0] car_acc = '0;
  logic signed [15:0] chirp_rom[HDR_LEN];
  logic [6:0]  cfg_spb = SPB_RESET;
  logic [15:0] cfg_step = STEP_RESET;
  logic [7:0]  cfg_pad = PAD_RESET;
  logic [9:0]  cfg_warm = WARM_RESET;

  // bookkeeping
  int errors = 0;
  int items_in = 0;
  int results_out = 0;
  int frames_sent = 0;
  int refused_cnt = 0;
  int cycle_cnt = 0;
  bit in_taken = 1'b0;
  int src_gap = 0;
  int snk_gap = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int run_left[2] = '{0, 0};
  bit quiet[2] = '{1'b0, 1'b0};

  bpsk_frame_transmitter_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [0] data_bit, [7:1] zero
    .s_axis_tlast  (s_axis_tlast),   // end_of_frame
    .s_axis_tuser  (s_axis_tuser),   // [1:0] action
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [15:0] sample
    .m_axis_tuser  (m_axis_tuser),   // [0] sample_valid, [1] playing, [2] load_refused
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- sine and carrier

  // quarter-wave polynomial in Q15, each product truncated
  function automatic int unsigned qwave_poly(int unsigned x);
    int unsigned x2;
    int unsigned t;
    x2 = (x * x) >> 15;
    t  = QB - ((QC * x2) >> 15);
    t  = QA - ((t * x2) >> 15);
    t  = (t * x) >> 15;
    return (t > 32767) ? 32767 : t;
  endfunction

  // sine of a 16-bit phase, sign and mirror by quadrant
  function automatic logic signed [15:0] sine16(logic [15:0] ph);
    int unsigned xq;
    int unsigned mag;
    xq  = 32'({ph[13:0], 1'b0});
    mag = ph[14] ? qwave_poly(32768 - xq) : qwave_poly(xq);
    return ph[15] ? -$signed(mag[15:0]) : $signed(mag[15:0]);
  endfunction

  // cosine of the accumulator, quantized to the table depth
  function automatic logic signed [15:0] carrier_now();
    longint unsigned k;
    longint unsigned p;
    k = 64'(car_acc);
    k = (k * COS_DEPTH) >> 16;
    p = (k << 16) / COS_DEPTH;
    return sine16(16'(p + 16384));
  endfunction

  // chirp instantaneous frequency, integer step kept
  function automatic longint unsigned chirp_hz(int i);
    int half;
    int stp;
    half = HDR_LEN / 2;
    stp  = (END_HZ - START_HZ) / half;
    if (i < half) return START_HZ + stp * i;
    if (i == half) return END_HZ;
    return END_HZ - stp * (i - half);
  endfunction

  // one carrier sample done; returns 1 when the bit period wraps
  function automatic bit step_carrier(int spb);
    sib++;
    car_acc = car_acc + cfg_step;
    if (sib >= spb) begin
      sib = 0;
      car_acc = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void close_frame();
    frm_rdy = 1'b0;
    frm_len = 0;
    tx_st   = TX_IDLE;
    ph_cnt  = 0;
  endfunction

  // ---------------------------------------------------------------- predictor

  // updates the predictor state for one input transfer, returns the sample transfer due
  function automatic tx_result_t predict_transfer(action_e act, bit dbit, bit eof);
    tx_result_t r;
    int spb;
    logic signed [15:0] c;
    r   = '0;
    spb = (cfg_spb == 0) ? 1 : ((cfg_spb > SPB_MAX) ? int'(SPB_MAX) : int'(cfg_spb));
    case (act)
      ACT_LOAD: begin
        if (frm_rdy || frm_len >= MAX_BITS) begin
          r.load_refused = 1'b1;
          refused_cnt++;
        end else begin
          bit_mem[frm_len] = dbit;
          frm_len++;
          if (eof) frm_rdy = 1'b1;
        end
      end
      ACT_START: begin
        if (tx_st == TX_IDLE && cfg_warm != 0) begin
          tx_st   = TX_WARM;
          ph_cnt  = 0;
          sib     = 0;
          car_acc = '0;
        end
      end
      ACT_TICK: begin
        r.sample_valid = 1'b1;
        // a ready frame skips straight to the preamble
        if (tx_st == TX_IDLE && frm_rdy) begin
          tx_st  = TX_PRE;
          ph_cnt = 0;
          frames_sent++;
        end
        case (tx_st)
          TX_WARM: begin
            r.sample = carrier_now();
            void'(step_carrier(spb));
            ph_cnt++;
            if (ph_cnt >= cfg_warm) begin
              tx_st  = TX_IDLE;
              ph_cnt = 0;
            end
          end
          TX_PRE: begin
            r.sample = chirp_rom[ph_cnt];
            ph_cnt++;
            if (ph_cnt >= HDR_LEN) begin
              tx_st   = TX_BITS;
              ph_cnt  = 0;
              bit_idx = 0;
              sib     = 0;
              car_acc = '0;
            end
          end
          TX_BITS: begin
            c = carrier_now();
            r.sample = bit_mem[bit_idx] ? c : -c;
            if (step_carrier(spb)) begin
              bit_idx++;
              if (bit_idx >= frm_len) begin
                tx_st  = TX_TAIL;
                ph_cnt = 0;
                if (cfg_pad == 0) close_frame();
              end
            end
          end
          TX_TAIL: begin
            ph_cnt++;
            if (ph_cnt >= cfg_pad) close_frame();
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    r.playing = (tx_st != TX_IDLE) || frm_rdy;
    return r;
  endfunction

  // ---------------------------------------------------------------- idle gaps

  // mostly short gaps, a few long, with stretches of none at all
  function automatic int next_gap(int side);
    int r;
    if (run_left[side] <= 0) begin
      quiet[side]    = ($urandom_range(0, 3) == 0);
      run_left[side] = $urandom_range(20, 200);
    end
    run_left[side]--;
    if (quiet[side]) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // ---------------------------------------------------------------- driver and monitor

  // input driver: next item once the current one is transferred
  always @(negedge clk_i) begin
    tx_item_t it;
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (stim_q.size() > 0) begin
        it = stim_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.act;
        s_axis_tdata  <= {7'd0, it.dbit};
        s_axis_tlast  <= it.eof;
        src_gap = next_gap(0);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result ready, with one long hold-off while items are still waiting to be sent
  always @(negedge clk_i) begin
    if (!hold_done && items_in >= 600 && stim_q.size() >= 20) begin
      hold_left = HOLD_LEN;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (snk_gap > 0) begin
      snk_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      snk_gap = next_gap(1);
    end
  end

  // check result transfers, predict on input transfers
  always @(posedge clk_i) begin
    tx_result_t due;
    in_taken = 1'b0;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_out++;
        if (due_results.size() == 0) begin
          $error("result transfer with no sample due: tdata %h tuser %b",
                 m_axis_tdata, m_axis_tuser);
          errors++;
        end else begin
          due = due_results.pop_front();
          if (m_axis_tdata !== due.sample) begin
            $error("sample: expected %0d, got %0d", due.sample, $signed(m_axis_tdata));
            errors++;
          end
          if (m_axis_tuser[0] !== due.sample_valid) begin
            $error("sample_valid: expected %0b, got %0b", due.sample_valid, m_axis_tuser[0]);
            errors++;
          end
          if (m_axis_tuser[1] !== due.playing) begin
            $error("playing: expected %0b, got %0b", due.playing, m_axis_tuser[1]);
            errors++;
          end
          if (m_axis_tuser[2] !== due.load_refused) begin
            $error("load_refused: expected %0b, got %0b", due.load_refused, m_axis_tuser[2]);
            errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        due_results.insert(due_results.size(),
                           predict_transfer(action_e'(s_axis_tuser), s_axis_tdata[0],
                                            s_axis_tlast));
        items_in++;
        in_taken = 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT) begin
      $display("[bpsk_frame_transmitter_top] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus helpers

  function automatic bit coin();
    return bit'($urandom_range(0, 1));
  endfunction

  task automatic queue_item(action_e act, bit dbit, bit eof);
    tx_item_t it;
    it.act  = act;
    it.dbit = dbit;
    it.eof  = eof;
    stim_q.insert(stim_q.size(), it);
    queued_items++;
  endtask

  task automatic queue_ticks(int n);
    repeat (n) queue_item(ACT_TICK, coin(), coin());
  endtask

  // wait until every item is sent and every sample has come back
  task automatic settle();
    do @(negedge clk_i);
    while (stim_q.size() != 0 || s_axis_tvalid || due_results.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, int unsigned val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[15:0];
    do @(posedge clk_i);
    while (!cfg_ready_o);
    case (idx)
      CFG_SAMPLES_PER_BIT: cfg_spb  = val[6:0];
      CFG_PHASE_STEP:      cfg_step = val[15:0];
      CFG_ZERO_PAD_LEN:    cfg_pad  = val[7:0];
      default:             cfg_warm = val[9:0];
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_all(int unsigned spb, int unsigned stp, int unsigned pad,
                           int unsigned warm);
    write_reg(CFG_SAMPLES_PER_BIT, spb);
    write_reg(CFG_PHASE_STEP, stp);
    write_reg(CFG_ZERO_PAD_LEN, pad);
    write_reg(CFG_WARMUP_LEN, warm);
  endtask

  // well-formed frames with random content, warm-up runs and some noise
  task automatic random_phase(int budget);
    int base;
    int kind;
    int n;
    int ticks;
    int spb;
    int room;
    bit warm_on;
    base = queued_items;
    spb  = (cfg_spb == 0) ? 1 : ((cfg_spb > SPB_MAX) ? int'(SPB_MAX) : int'(cfg_spb));
    while (queued_items - base < budget) begin
      room = budget - (queued_items - base);
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        // frame with enough ticks to play it out, sometimes cut short
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        warm_on = ($urandom_range(0, 3) == 0);
        if (warm_on) queue_item(ACT_START, coin(), coin());
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 5) == 0) queue_item(coin() ? ACT_TICK : ACT_NOP, coin(), coin());
          queue_item(ACT_LOAD, coin(), i == n - 1);
        end
        if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 2))
          queue_item(ACT_LOAD, coin(), coin());
        ticks = HDR_LEN + (n + 4) * spb + cfg_pad + (warm_on ? cfg_warm : 0) +
                $urandom_range(0, 10);
        if ($urandom_range(0, 4) == 0) ticks = $urandom_range(1, ticks);
        // a frame left unfinished plays on in the next part
        if (ticks > room) ticks = room;
        for (int i = 0; i < ticks; i++) begin
          if ($urandom_range(0, 29) == 0) queue_item(coin() ? ACT_START : ACT_LOAD, coin(), coin());
          queue_item(ACT_TICK, coin(), coin());
        end
      end else if (kind < 8) begin
        // warm-up run
        queue_item(ACT_START, coin(), coin());
        ticks = $urandom_range(0, cfg_warm + 5);
        queue_ticks((ticks > room) ? room : ticks);
      end else begin
        // noise
        repeat ($urandom_range(1, 12)) queue_item(action_e'($urandom_range(0, 3)), coin(), coin());
      end
    end
  endtask

  // ---------------------------------------------------------------- test sequence

  initial begin
    longint unsigned s_acc;
    longint unsigned ph;

    // preamble samples from the chirp phase sum
    s_acc = 0;
    chirp_rom[0] = '0;
    for (int i = 1; i < HDR_LEN; i++) begin
      s_acc += chirp_hz(i) + chirp_hz(i - 1);
      ph = (s_acc * 65536 + RATE_HZ) / (2 * RATE_HZ);
      chirp_rom[i] = sine16(ph[15:0]);
    end

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: silence, then a warm-up left running
    queue_item(ACT_NOP, 1'b1, 1'b1);
    queue_item(ACT_TICK, 1'b0, 1'b0);
    queue_item(ACT_START, 1'b0, 1'b0);
    queue_ticks(3);
    settle();

    // short bits, top step, no padding; warm-up cut by the lowered length
    write_all(2, 16'hFFFF, 0, 3);
    queue_item(ACT_TICK, 1'b0, 1'b0);
    queue_item(ACT_LOAD, 1'b1, 1'b0);
    queue_item(ACT_LOAD, 1'b0, 1'b1);
    queue_item(ACT_LOAD, 1'b1, 1'b1);   // refused, frame pending
    queue_item(ACT_START, 1'b1, 1'b0);  // idle, so warm-up first
    queue_ticks(3 + HDR_LEN + 4 + 2);
    queue_item(ACT_START, 1'b0, 1'b1);
    queue_ticks(2);
    queue_item(ACT_START, 1'b1, 1'b1);  // ignored mid warm-up
    queue_ticks(2);
    settle();

    // zero samples per bit, zero step, longest padding, warm-up disabled
    write_all(0, 0, 255, 0);
    queue_item(ACT_START, 1'b0, 1'b0);
    queue_item(ACT_LOAD, 1'b1, 1'b1);
    queue_item(ACT_START, 1'b0, 1'b0);
    queue_ticks(HDR_LEN + 1 + 255 + 2);
    settle();

    // oversized bit period and longest warm-up, then registers lowered mid-run
    write_all(127, 6827, 20, 1023);
    queue_item(ACT_START, 1'b0, 1'b0);
    queue_ticks(40);
    settle();
    write_reg(CFG_WARMUP_LEN, 5);
    queue_ticks(2);
    queue_item(ACT_LOAD, 1'b1, 1'b1);
    queue_ticks(HDR_LEN + 10);
    settle();
    write_reg(CFG_SAMPLES_PER_BIT, 3);
    queue_ticks(6);
    settle();
    write_reg(CFG_ZERO_PAD_LEN, 2);
    queue_ticks(3);
    settle();

    // random phases over a spread of settings
    for (int p = 0; p < 6; p++) begin
      write_all((p == 2) ? 64 : ((p == 0) ? 1 : $urandom_range(1, 6)),
                (p == 1) ? 16'hFFFF : ((p == 3) ? 0 : $urandom_range(0, 65535)),
                (p == 4) ? 255 : $urandom_range(0, 12),
                (p == 5) ? 1023 : $urandom_range(0, 40));
      random_phase(80);
      settle();
    end

    $display("run covered %0d input transfers and %0d sample transfers, %0d frames sent",
             items_in, results_out, frames_sent);
    $display("%0d loads refused, output held off once for %0d cycles", refused_cnt, HOLD_LEN);
    if (errors == 0) begin
      $display("[bpsk_frame_transmitter_top] OK");
    end else begin
      $display("[bpsk_frame_transmitter_top] ERROR");
    end
    $finish;
  end

endmodule
